@@ design/mpd_pkg.sv @@
`default_nettype none

package mpd_pkg;

    // Hash length in bytes for the destination and source address fields.
    localparam int HASH_BYTES = 16;

    // Byte position counter; saturates at its all-ones value.
    localparam int POS_W = 11;

    // Default depth of the front-to-back queue.
    localparam int Q_DEPTH = 2;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] ADDR_DEFAULT_CONTEXT = 3'h0;

    // Header bit positions.
    localparam int HDR_IFAC_BIT  = 7;
    localparam int HDR_TWO_BIT   = 6;
    localparam int HDR_CTX_BIT   = 5;
    localparam int HDR_PROP_BIT  = 4;
    localparam int HDR_DEST_HI   = 3;
    localparam int HDR_DEST_LO   = 2;
    localparam int HDR_PTYPE_HI  = 1;
    localparam int HDR_PTYPE_LO  = 0;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [POS_W:0]   t_pos_ext;

    localparam t_pos     POS_LIMIT = '1;
    localparam t_pos_ext DST_END   = t_pos_ext'(2 + HASH_BYTES);
    localparam t_pos_ext HASH_EXT  = t_pos_ext'(HASH_BYTES);

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_HOPS    = 3'd1,
        KIND_DEST    = 3'd2,
        KIND_SOURCE  = 3'd3,
        KIND_CONTEXT = 3'd4,
        KIND_PAYLOAD = 3'd5
    } t_kind;

    // One classified beat, passed from the front to the back.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic        last;
        logic        trunc;
        logic [7:0]  hdr;
        logic [7:0]  hops;
        logic        ctx_ok;
        logic [7:0]  ctx_byte;
    } t_entry;

endpackage

`default_nettype wire

@@ design/mpd_in_if.sv @@
`default_nettype none

interface mpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

@@ design/mpd_out_if.sv @@
`default_nettype none

interface mpd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] field_kind;
    logic [7:0] byte_value;
    logic       packet_end;
    logic       status;
    logic       ifac_flag;
    logic       two_address;
    logic       has_context;
    logic       propagation;
    logic [1:0] dest_kind;
    logic [1:0] kind_of_packet;
    logic [7:0] hop_count;
    logic [7:0] context_value;

    modport source (
        output valid, output field_kind, output byte_value, output packet_end,
        output status, output ifac_flag, output two_address, output has_context,
        output propagation, output dest_kind, output kind_of_packet,
        output hop_count, output context_value,
        input  ready
    );
    modport sink (
        input  valid, input field_kind, input byte_value, input packet_end,
        input  status, input ifac_flag, input two_address, input has_context,
        input  propagation, input dest_kind, input kind_of_packet,
        input  hop_count, input context_value,
        output ready
    );
endinterface

`default_nettype wire

@@ design/mpd_front.sv @@
`default_nettype none

module mpd_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    mpd_in_if.sink           i_in,
    input  wire              i_q_full,
    output logic             o_push,
    output mpd_pkg::t_entry  o_entry
);

    mpd_pkg::t_pos     r_pos;
    mpd_pkg::t_pos     n_pos;
    logic [7:0]        r_hdr;
    logic [7:0]        n_hdr;
    logic [7:0]        r_hops;
    logic [7:0]        n_hops;
    logic [7:0]        r_ctx;
    logic [7:0]        n_ctx;

    logic              accept;
    logic [7:0]        hdr;
    logic [7:0]        hops;
    logic              two;
    logic              ctx;
    mpd_pkg::t_pos_ext pos_ext;
    mpd_pkg::t_pos_ext pos_next;
    mpd_pkg::t_pos_ext src_end;
    mpd_pkg::t_pos_ext required;
    mpd_pkg::t_kind    kind;
    logic              trunc;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign o_push     = accept;

    assign pos_ext  = {1'b0, r_pos};
    assign pos_next = pos_ext + mpd_pkg::t_pos_ext'(1);

    always_comb begin
        hdr  = (r_pos == '0) ? i_in.data_byte : r_hdr;
        if (r_pos == mpd_pkg::t_pos'(1)) begin
            hops = i_in.data_byte;
        end else if (r_pos == '0) begin
            hops = '0;
        end else begin
            hops = r_hops;
        end
        two      = hdr[mpd_pkg::HDR_TWO_BIT];
        ctx      = hdr[mpd_pkg::HDR_CTX_BIT];
        src_end  = mpd_pkg::DST_END + (two ? mpd_pkg::HASH_EXT : '0);
        required = src_end + mpd_pkg::t_pos_ext'(ctx);
        trunc    = pos_next < required;

        priority if (r_pos == '0) begin
            kind = mpd_pkg::KIND_HEADER;
        end else if (r_pos == mpd_pkg::t_pos'(1)) begin
            kind = mpd_pkg::KIND_HOPS;
        end else if (pos_ext < mpd_pkg::DST_END) begin
            kind = mpd_pkg::KIND_DEST;
        end else if (pos_ext < src_end) begin
            kind = mpd_pkg::KIND_SOURCE;
        end else if (ctx && pos_ext == src_end) begin
            kind = mpd_pkg::KIND_CONTEXT;
        end else begin
            kind = mpd_pkg::KIND_PAYLOAD;
        end

        o_entry.kind     = kind;
        o_entry.data     = i_in.data_byte;
        o_entry.last     = i_in.last_byte;
        o_entry.trunc    = trunc;
        o_entry.hdr      = hdr;
        o_entry.hops     = hops;
        o_entry.ctx_ok   = ctx && !trunc;
        o_entry.ctx_byte = (kind == mpd_pkg::KIND_CONTEXT) ? i_in.data_byte : r_ctx;
    end

    always_comb begin
        n_pos  = r_pos;
        n_hdr  = r_hdr;
        n_hops = r_hops;
        n_ctx  = r_ctx;
        if (accept) begin
            if (r_pos == '0) begin
                n_hdr = i_in.data_byte;
            end
            if (r_pos == mpd_pkg::t_pos'(1)) begin
                n_hops = i_in.data_byte;
            end
            if (kind == mpd_pkg::KIND_CONTEXT) begin
                n_ctx = i_in.data_byte;
            end
            // Restart on the last beat, otherwise advance and hold at the limit.
            if (i_in.last_byte) begin
                n_pos = '0;
            end else if (r_pos != mpd_pkg::POS_LIMIT) begin
                n_pos = r_pos + mpd_pkg::t_pos'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_hdr  <= '0;
            r_hops <= '0;
            r_ctx  <= '0;
        end else begin
            r_pos  <= n_pos;
            r_hdr  <= n_hdr;
            r_hops <= n_hops;
            r_ctx  <= n_ctx;
        end
    end

    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.last_byte) |=> (r_pos == '0))
        else $error("position not cleared after last beat");

    a_hold_without_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> (r_pos == $past(r_pos) && r_hdr == $past(r_hdr)))
        else $error("front state moved without an accepted beat");

endmodule

`default_nettype wire

@@ design/mpd_queue.sv @@
`default_nettype none

module mpd_queue #(
    parameter int DEPTH = mpd_pkg::Q_DEPTH
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  mpd_pkg::t_entry  i_entry,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_valid,
    output mpd_pkg::t_entry  o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    mpd_pkg::t_entry  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count above depth");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into a full queue");

endmodule

`default_nettype wire

@@ design/mpd_back.sv @@
`default_nettype none

module mpd_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire  [7:0]       i_default_context,
    input  wire              i_q_valid,
    input  mpd_pkg::t_entry  i_entry,
    output logic             o_pop,
    mpd_out_if.source        o_out
);

    logic       r_valid;
    logic       n_valid;
    logic [2:0] r_kind;
    logic [7:0] r_byte;
    logic       r_end;
    logic       r_status;
    logic       r_ifac;
    logic       r_two;
    logic       r_ctx;
    logic       r_prop;
    logic [1:0] r_dest;
    logic [1:0] r_ptype;
    logic [7:0] r_hops;
    logic [7:0] r_ctx_val;

    logic [7:0] hdr;
    logic       last;

    // Load a new beat when the output stage is empty or being drained.
    assign o_pop   = i_q_valid && (!r_valid || o_out.ready);
    assign hdr     = i_entry.hdr;
    assign last    = i_entry.last;

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Decoded fields read zero except on the last beat of a packet.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind    <= i_entry.kind;
            r_byte    <= i_entry.data;
            r_end     <= last;
            r_status  <= last && i_entry.trunc;
            r_ifac    <= last && hdr[mpd_pkg::HDR_IFAC_BIT];
            r_two     <= last && hdr[mpd_pkg::HDR_TWO_BIT];
            r_ctx     <= last && hdr[mpd_pkg::HDR_CTX_BIT];
            r_prop    <= last && hdr[mpd_pkg::HDR_PROP_BIT];
            r_dest    <= last ? hdr[mpd_pkg::HDR_DEST_HI:mpd_pkg::HDR_DEST_LO] : '0;
            r_ptype   <= last ? hdr[mpd_pkg::HDR_PTYPE_HI:mpd_pkg::HDR_PTYPE_LO] : '0;
            r_hops    <= last ? i_entry.hops : '0;
            r_ctx_val <= !last ? '0 :
                         (i_entry.ctx_ok ? i_entry.ctx_byte : i_default_context);
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.field_kind     = r_kind;
    assign o_out.byte_value     = r_byte;
    assign o_out.packet_end     = r_end;
    assign o_out.status         = r_status;
    assign o_out.ifac_flag      = r_ifac;
    assign o_out.two_address    = r_two;
    assign o_out.has_context    = r_ctx;
    assign o_out.propagation    = r_prop;
    assign o_out.dest_kind      = r_dest;
    assign o_out.kind_of_packet = r_ptype;
    assign o_out.hop_count      = r_hops;
    assign o_out.context_value  = r_ctx_val;

    a_quiet_midpacket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_end) |-> (r_status == 1'b0 && r_hops == '0 && r_ctx_val == '0))
        else $error("decoded fields set on a beat that is not last");

    a_no_pop_while_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_out.ready) |-> !o_pop)
        else $error("output stage overwritten while stalled");

endmodule

`default_nettype wire

@@ design/mesh_packet_header_deframer.sv @@
// Channel    Dir  Handshake        Beat
// i_in       in   valid/ready      data_byte, last_byte
// o_out      out  valid/ready      field_kind, byte_value, end flags, decoded header
// cfg (APB)  in   psel/penable     default_context at byte address 0
//
// One byte a cycle while the queue has room: the front classifies a byte in the
// cycle it is accepted, with one position counter and compare.
// An accepted byte passes through the queue, then the output register, to o_out.
// Reset is synchronous, active low; it clears the counter, header stores and queue.
// The two-entry queue lets the front keep taking bytes while o_out is stalled;
// i_in.ready drops only when the queue is full.

`default_nettype none

module mesh_packet_header_deframer #(
    parameter int Q_DEPTH = mpd_pkg::Q_DEPTH
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    mpd_in_if.sink                           i_in,
    mpd_out_if.source                        o_out,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [mpd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire  [mpd_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [mpd_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);

    logic [7:0]      r_def_ctx;
    logic [7:0]      n_def_ctx;
    logic            cfg_wr;

    logic            push;
    logic            q_full;
    logic            q_valid;
    logic            pop;
    mpd_pkg::t_entry front_entry;
    mpd_pkg::t_entry back_entry;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == mpd_pkg::ADDR_DEFAULT_CONTEXT);

    always_comb begin
        n_def_ctx = r_def_ctx;
        if (cfg_wr) begin
            n_def_ctx = pwdata[7:0];
        end
        prdata = '0;
        if (paddr == mpd_pkg::ADDR_DEFAULT_CONTEXT) begin
            prdata = mpd_pkg::CFG_DATA_W'(r_def_ctx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_ctx <= '0;
        end else begin
            r_def_ctx <= n_def_ctx;
        end
    end

    mpd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_entry  (front_entry)
    );

    mpd_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (back_entry)
    );

    mpd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_default_context (r_def_ctx),
        .i_q_valid         (q_valid),
        .i_entry           (back_entry),
        .o_pop             (pop),
        .o_out             (o_out)
    );

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 64;
    localparam int PHASE_BYTES  = 310;
    localparam int MAX_REPORTS  = 40;

    typedef struct packed {
        mpd_pkg::t_kind kind;
        logic [7:0] value;
        logic       pkt_end;
        logic       status;
        logic       ifac;
        logic       two_addr;
        logic       ctx_flag;
        logic       prop;
        logic [1:0] dest;
        logic [1:0] ptype;
        logic [7:0] hops;
        logic [7:0] ctx_val;
    } t_fields;

    // One row sends reps copies of data; last marks only the final copy.
    // Where known is set, want is the expected result of that final copy.
    typedef struct packed {
        logic [7:0]  data;
        logic [11:0] reps;
        logic        last;
        logic        known;
        t_fields     want;
    } t_dir_row;

    localparam int DIR_ROWS = 9;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        // one-byte packet, all header bits set: truncated, default context
        '{8'hFF, 12'd1, 1'b1, 1'b1,
          '{mpd_pkg::KIND_HEADER, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
            2'd3, 2'd3, 8'h00, 8'h00}},
        // one-byte packet, all header bits clear
        '{8'h00, 12'd1, 1'b1, 1'b1,
          '{mpd_pkg::KIND_HEADER, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
            2'd0, 2'd0, 8'h00, 8'h00}},
        // context flag set but packet ends on the hops byte
        '{8'h20, 12'd1, 1'b0, 1'b0, '0},
        '{8'hFF, 12'd1, 1'b1, 1'b1,
          '{mpd_pkg::KIND_HOPS, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
            2'd0, 2'd0, 8'hFF, 8'h00}},
        // shortest complete packet: ends on the last destination hash byte
        '{8'h0F, 12'd1, 1'b0, 1'b0, '0},
        '{8'h00, 12'd1, 1'b0, 1'b0, '0},
        '{8'h80, 12'(mpd_pkg::HASH_BYTES - 1), 1'b0, 1'b0, '0},
        '{8'h7F, 12'd1, 1'b1, 1'b0, '0},
        '{8'h55, 12'd1, 1'b1, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [mpd_pkg::CFG_ADDR_W-1:0] paddr;
    logic [mpd_pkg::CFG_DATA_W-1:0] pwdata;
    wire  [mpd_pkg::CFG_DATA_W-1:0] prdata;
    wire                            pready;

    mpd_in_if  byte_ch ();
    mpd_out_if field_ch ();

    mesh_packet_header_deframer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (field_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow state of the deframer
    logic [mpd_pkg::POS_W-1:0] pos_q;
    logic [7:0]       hdr_q;
    logic [7:0]       hops_q;
    logic [7:0]       ctx_q;
    logic [7:0]       dflt_ctx;

    t_fields pending_fields[$];
    int      mismatch_count;
    int      cycle_count;
    int      src_idle_pct;
    int      snk_stall_pct;
    bit      hold_req;
    int      hold_left;
    bit      beat_typed;
    t_fields beat_want;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_fields classify_byte(input logic [7:0] b, input logic l);
        t_fields r;
        int      p;
        logic [7:0] hdr;
        logic [7:0] hops;
        int      dst_end;
        int      src_end;
        int      need;
        logic    trunc;
        p       = int'(pos_q);
        hdr     = (p == 0) ? b : hdr_q;
        hops    = (p == 1) ? b : ((p == 0) ? 8'h00 : hops_q);
        dst_end = 2 + mpd_pkg::HASH_BYTES;
        src_end = dst_end + (hdr[mpd_pkg::HDR_TWO_BIT] ? mpd_pkg::HASH_BYTES : 0);
        need    = src_end + (hdr[mpd_pkg::HDR_CTX_BIT] ? 1 : 0);
        r       = '0;
        if (p == 0) r.kind = mpd_pkg::KIND_HEADER;
        else if (p == 1) r.kind = mpd_pkg::KIND_HOPS;
        else if (p < dst_end) r.kind = mpd_pkg::KIND_DEST;
        else if (p < src_end) r.kind = mpd_pkg::KIND_SOURCE;
        else if (hdr[mpd_pkg::HDR_CTX_BIT] && p == src_end) r.kind = mpd_pkg::KIND_CONTEXT;
        else r.kind = mpd_pkg::KIND_PAYLOAD;
        r.value = b;
        if (p == 0) hdr_q = b;
        if (p == 1) hops_q = b;
        if (r.kind == mpd_pkg::KIND_CONTEXT) ctx_q = b;
        if (l) begin
            trunc      = (p + 1) < need;
            r.pkt_end  = 1'b1;
            r.status   = trunc;
            r.ifac     = hdr[mpd_pkg::HDR_IFAC_BIT];
            r.two_addr = hdr[mpd_pkg::HDR_TWO_BIT];
            r.ctx_flag = hdr[mpd_pkg::HDR_CTX_BIT];
            r.prop     = hdr[mpd_pkg::HDR_PROP_BIT];
            r.dest     = hdr[mpd_pkg::HDR_DEST_HI:mpd_pkg::HDR_DEST_LO];
            r.ptype    = hdr[mpd_pkg::HDR_PTYPE_HI:mpd_pkg::HDR_PTYPE_LO];
            r.hops     = hops;
            r.ctx_val  = (hdr[mpd_pkg::HDR_CTX_BIT] && !trunc) ? ctx_q : dflt_ctx;
            pos_q      = '0;
        end else if (pos_q != mpd_pkg::POS_LIMIT) begin
            pos_q = pos_q + 1'b1;
        end
        return r;
    endfunction

    function automatic void note_diff(input string name, input logic [7:0] e,
                                      input logic [7:0] a);
        if (e !== a) begin
            if (mismatch_count < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
            mismatch_count++;
        end
    endfunction

    // Predict on every accepted input beat, check every accepted output beat
    always @(posedge i_clk) begin : scoreboard
        t_fields got;
        t_fields want;
        t_fields pred;
        if (i_rst_n) begin
            if (byte_ch.valid && byte_ch.ready) begin
                pred = classify_byte(byte_ch.data_byte, byte_ch.last_byte);
                pending_fields.push_back(beat_typed ? beat_want : pred);
            end
            if (field_ch.valid && field_ch.ready) begin
                got = '{mpd_pkg::t_kind'(field_ch.field_kind), field_ch.byte_value,
                        field_ch.packet_end, field_ch.status, field_ch.ifac_flag,
                        field_ch.two_address, field_ch.has_context, field_ch.propagation,
                        field_ch.dest_kind, field_ch.kind_of_packet, field_ch.hop_count,
                        field_ch.context_value};
                if (pending_fields.size() == 0) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("%0t: unexpected beat, expected none actual %0h",
                                 $time, got);
                    mismatch_count++;
                end else begin
                    want = pending_fields.pop_front();
                    note_diff("field_kind", 8'(want.kind), 8'(got.kind));
                    note_diff("byte_value", want.value, got.value);
                    note_diff("packet_end", 8'(want.pkt_end), 8'(got.pkt_end));
                    note_diff("status", 8'(want.status), 8'(got.status));
                    note_diff("ifac_flag", 8'(want.ifac), 8'(got.ifac));
                    note_diff("two_address", 8'(want.two_addr), 8'(got.two_addr));
                    note_diff("has_context", 8'(want.ctx_flag), 8'(got.ctx_flag));
                    note_diff("propagation", 8'(want.prop), 8'(got.prop));
                    note_diff("dest_kind", 8'(want.dest), 8'(got.dest));
                    note_diff("kind_of_packet", 8'(want.ptype), 8'(got.ptype));
                    note_diff("hop_count", want.hops, got.hops);
                    note_diff("context_value", want.ctx_val, got.ctx_val);
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        field_ch.ready = 1'b0;
        hold_left      = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                field_ch.ready <= 1'b0;
            end else begin
                field_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
            end
        end
    end

    // Called and returns at a falling edge; valid stays high on return
    task automatic send_byte(input logic [7:0] b, input logic l, input bit typed,
                             input t_fields want);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            byte_ch.valid     <= 1'b0;
            byte_ch.data_byte <= 8'($urandom_range(0, 255));
            @(negedge i_clk);
        end
        beat_typed = typed;
        beat_want  = want;
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= l;
        do @(posedge i_clk); while (!byte_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic send_packet(input logic [7:0] hdr, input int len);
        for (int k = 0; k < len; k++) begin
            send_byte((k == 0) ? hdr : 8'($urandom_range(0, 255)), k == len - 1,
                      1'b0, '0);
        end
    endtask

    task automatic wait_idle();
        byte_ch.valid <= 1'b0;
        while (pending_fields.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [mpd_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [mpd_pkg::CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == mpd_pkg::ADDR_DEFAULT_CONTEXT) dflt_ctx = value[7:0];
    endtask

    // Mostly complete packets, some cut short, some with a long payload
    task automatic run_packets(input int budget);
        int sent;
        int need;
        int len;
        int pick;
        logic [7:0] hdr;
        sent = 0;
        while (sent < budget) begin
            hdr  = 8'($urandom_range(0, 255));
            need = 2 + mpd_pkg::HASH_BYTES
                 + (hdr[mpd_pkg::HDR_TWO_BIT] ? mpd_pkg::HASH_BYTES : 0)
                 + (hdr[mpd_pkg::HDR_CTX_BIT] ? 1 : 0);
            pick = $urandom_range(0, 99);
            if (pick < 75) len = need + $urandom_range(0, 6);
            else if (pick < 92) len = $urandom_range(1, need - 1);
            else len = need + $urandom_range(7, 40);
            send_packet(hdr, len);
            sent += len;
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = 8'h00;
        byte_ch.last_byte = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        pos_q             = '0;
        hdr_q             = 8'h00;
        hops_q            = 8'h00;
        ctx_q             = 8'h00;
        dflt_ctx          = 8'h00;
        mismatch_count    = 0;
        src_idle_pct      = 0;
        snk_stall_pct     = 0;
        hold_req          = 1'b0;
        beat_typed        = 1'b0;
        beat_want         = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int row = 0; row < DIR_ROWS; row++) begin
            for (int r = 0; r < int'(DIRECTED[row].reps); r++) begin
                send_byte(DIRECTED[row].data,
                          DIRECTED[row].last && (r == int'(DIRECTED[row].reps) - 1),
                          DIRECTED[row].known && (r == int'(DIRECTED[row].reps) - 1),
                          DIRECTED[row].want);
            end
        end
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_reg(mpd_pkg::ADDR_DEFAULT_CONTEXT, 32'h0000_00FF);
                1: write_reg(mpd_pkg::ADDR_DEFAULT_CONTEXT, 32'($urandom_range(1, 254)));
                2: write_reg(mpd_pkg::ADDR_DEFAULT_CONTEXT, 32'h0000_0000);
                default: write_reg(mpd_pkg::ADDR_DEFAULT_CONTEXT,
                                   32'($urandom_range(0, 255)));
            endcase
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 68; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 68; end
                default: begin src_idle_pct = 35; snk_stall_pct = 35; end
            endcase
            // hold the receiver in the first phase while bytes keep coming
            if (ph == 0) hold_req = 1'b1;
            run_packets(PHASE_BYTES);
            wait_idle();
        end

        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
